### hdl/u2u_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16/UTF-32 stream decoder.
// Used by u2u_dec, u2u_outq and utf8_stream_to_utf16_utf32; depends on nothing.
`default_nettype none

package u2u_pkg;

    // Result status codes.
    localparam logic [1:0] ST_VALID   = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_TRUNC   = 2'd2;

    // Output mode register values.
    localparam logic MODE_UTF16 = 1'b0;
    localparam logic MODE_UTF32 = 1'b1;

    // Lead byte classification limits.
    localparam logic [7:0] LEAD_MIN_2 = 8'hC2;
    localparam logic [7:0] LEAD_MIN_3 = 8'hE0;
    localparam logic [7:0] LEAD_MIN_4 = 8'hF0;
    localparam logic [7:0] LEAD_MAX_4 = 8'hF4;

    // Second-byte windows on (lead << 6) + byte.
    localparam logic [13:0] RAW3_MIN      = 14'h38A0;
    localparam logic [13:0] RAW3_SURR_LO  = 14'h3BE0;
    localparam logic [13:0] RAW3_SURR_HI  = 14'h3BFF;
    localparam logic [13:0] RAW4_MIN      = 14'h3C90;
    localparam logic [13:0] RAW4_MAX      = 14'h3D8F;

    // Surrogate bases.
    localparam logic [15:0] SURR_HIGH_BASE = 16'hD800;
    localparam logic [15:0] SURR_LOW_BASE  = 16'hDC00;

    // One input item.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       flush;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [20:0] code_unit;
        logic [1:0]  status;
        logic [2:0]  seq_bytes;
        logic        last;
    } t_out_item;

    // Results produced by one decoded item: zero, one or two.
    typedef struct packed {
        logic [1:0] count;
        t_out_item  item0;
        t_out_item  item1;
    } t_push;

endpackage

`default_nettype wire

### hdl/u2u_dec.sv
// Input register, pending-sequence state and single-pass UTF-8 decode logic.
// Depends on u2u_pkg; feeds u2u_outq with up to two results per item.
`default_nettype none

module u2u_dec (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_mode,
    input  wire logic               i_in_valid,
    input  wire u2u_pkg::t_in_item  i_in_item,
    output logic                    o_in_stall,
    input  wire logic               i_space,
    output u2u_pkg::t_push          o_push
);
    import u2u_pkg::*;

    logic        r_in_valid;
    t_in_item    r_in;
    logic [1:0]  r_exp;
    logic [14:0] r_acc;
    logic [2:0]  r_len;

    logic [1:0]  n_exp;
    logic [14:0] n_acc;
    logic [2:0]  n_len;

    logic        advance;
    logic        fail;
    logic [1:0]  fail_status;
    logic        emit;
    logic [20:0] cp;
    logic [2:0]  emit_len;
    logic [7:0]  b;
    logic [20:0] acc_new;
    logic [13:0] raw3;
    logic [13:0] raw4;
    logic [19:0] sup;
    t_push       push;

    // The held item moves on when the result queue can take two results.
    assign advance    = r_in_valid && i_space;
    assign o_in_stall = r_in_valid && !i_space;

    assign b       = r_in.in_byte;
    assign acc_new = {r_acc, b[5:0]};
    assign raw3    = {4'b1110, r_acc[3:0], 6'b0} + {6'b0, b};
    assign raw4    = {5'b11110, r_acc[2:0], 6'b0} + {6'b0, b};
    assign sup     = cp[19:0] - 20'h10000;

    // Decode one item against the pending sequence.
    always_comb begin
        n_exp       = r_exp;
        n_acc       = r_acc;
        n_len       = r_len;
        fail        = 1'b0;
        fail_status = ST_INVALID;
        emit        = 1'b0;
        cp          = '0;
        emit_len    = 3'd1;
        if (r_in.flush) begin
            if (r_exp != 2'd0) begin
                fail        = 1'b1;
                fail_status = ST_TRUNC;
            end
        end else if (r_exp == 2'd0) begin
            if (!b[7]) begin
                emit     = 1'b1;
                cp       = {13'b0, b};
                emit_len = 3'd1;
            end else if (b < LEAD_MIN_2) begin
                fail = 1'b1;
            end else if (b < LEAD_MIN_3) begin
                n_exp = 2'd1;
                n_acc = {10'b0, b[4:0]};
                n_len = 3'd2;
            end else if (b < LEAD_MIN_4) begin
                n_exp = 2'd2;
                n_acc = {11'b0, b[3:0]};
                n_len = 3'd3;
            end else if (b <= LEAD_MAX_4) begin
                n_exp = 2'd3;
                n_acc = {12'b0, b[2:0]};
                n_len = 3'd4;
            end else begin
                fail = 1'b1;
            end
        end else if (b[7:6] != 2'b10) begin
            fail = 1'b1;
        end else if (r_len == 3'd3 && r_exp == 2'd2 &&
                     (raw3 < RAW3_MIN || (raw3 >= RAW3_SURR_LO && raw3 <= RAW3_SURR_HI))) begin
            // Overlong three-byte form or an encoded surrogate.
            fail = 1'b1;
        end else if (r_len == 3'd4 && r_exp == 2'd3 &&
                     (raw4 < RAW4_MIN || raw4 > RAW4_MAX)) begin
            // Overlong four-byte form or a code point above 10FFFF.
            fail = 1'b1;
        end else if (r_exp == 2'd1) begin
            emit     = 1'b1;
            cp       = acc_new;
            emit_len = r_len;
        end else begin
            n_exp = r_exp - 2'd1;
            n_acc = acc_new[14:0];
        end

        if (fail || emit) begin
            n_exp = '0;
            n_acc = '0;
            n_len = '0;
        end
    end

    // Format the results of this item.
    always_comb begin
        push       = '0;
        push.item0 = '{code_unit: 21'd0, status: fail_status, seq_bytes: 3'd0, last: 1'b1};
        if (fail) begin
            push.count = 2'd1;
        end else if (emit) begin
            if (i_mode == MODE_UTF32 || cp[20:16] == 5'd0) begin
                push.count = 2'd1;
                push.item0 = '{code_unit: cp, status: ST_VALID, seq_bytes: emit_len,
                               last: 1'b1};
            end else begin
                push.count = 2'd2;
                push.item0 = '{code_unit: {5'b0, SURR_HIGH_BASE | {6'b0, sup[19:10]}},
                               status: ST_VALID, seq_bytes: emit_len, last: 1'b0};
                push.item1 = '{code_unit: {5'b0, SURR_LOW_BASE | {6'b0, sup[9:0]}},
                               status: ST_VALID, seq_bytes: emit_len, last: 1'b1};
            end
        end
        if (!advance) begin
            push.count = 2'd0;
        end
    end

    assign o_push = push;

    // Input register and pending-sequence state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_exp      <= '0;
            r_acc      <= '0;
            r_len      <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_exp <= n_exp;
                r_acc <= n_acc;
                r_len <= n_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    // A pending sequence always has more bytes in total than still expected.
    a_len_vs_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_exp != 2'd0 |-> r_len == {1'b0, r_exp} + 3'd1 ||
                          (r_len == 3'd4 && r_exp != 2'd3) ||
                          (r_len == 3'd3 && r_exp == 2'd1))
        else $error("pending length out of step with expected count");

    // Error and truncation results come alone.
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.count != 2'd0 && push.item0.status != ST_VALID |-> push.count == 2'd1)
        else $error("error result paired with another result");

    // A surrogate pair is only produced in UTF-16 mode from a four-byte sequence.
    a_pair_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.count == 2'd2 |-> i_mode == MODE_UTF16 && push.item0.seq_bytes == 3'd4)
        else $error("surrogate pair outside UTF-16 four-byte case");

    // Every result ends the pending sequence.
    a_idle_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.count != 2'd0 |=> r_exp == 2'd0)
        else $error("state left pending after a result");

endmodule

`default_nettype wire

### hdl/u2u_outq.sv
// Four-entry result queue: takes up to two results a cycle, hands out one while the output is not stalled.
// Depends on u2u_pkg; fed by u2u_dec.
`default_nettype none

module u2u_outq (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire u2u_pkg::t_push   i_push,
    output logic                  o_space,
    output logic                  o_out_valid,
    output u2u_pkg::t_out_item    o_out_item,
    input  wire logic             i_out_stall
);
    import u2u_pkg::*;

    t_out_item  r_mem [4];
    logic [1:0] r_wr;
    logic [1:0] r_rd;
    logic [2:0] r_count;
    logic       pop;

    assign o_out_valid = r_count != 3'd0;
    assign o_out_item  = r_mem[r_rd];
    assign pop         = o_out_valid && !i_out_stall;
    // Room for two more results once this cycle's transfer is counted.
    assign o_space     = r_count <= 3'd2 || (r_count == 3'd3 && pop);

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + i_push.count;
            r_rd    <= r_rd + {1'b0, pop};
            r_count <= r_count + {1'b0, i_push.count} - {2'b0, pop};
        end
    end

    // Result storage.
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.item0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[r_wr + 2'd1] <= i_push.item1;
        end
    end

    // The queue never overflows.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4)
        else $error("result queue overflow");

    // Pushes only arrive when room was announced.
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.count != 2'd0 |-> o_space)
        else $error("push without room");

    // A transfer with no push lowers the count by one.
    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && i_push.count == 2'd0 |=> r_count == $past(r_count) - 3'd1)
        else $error("fill count out of step with transfers");

endmodule

`default_nettype wire

### hdl/utf8_stream_to_utf16_utf32.sv
// UTF-8 stream decoder with a UTF-16 or UTF-32 result stream.
// One UTF-8 byte (or a flush) enters per cycle while o_in_stall is low. Each
// accepted byte is held in an input register, decoded in a single pass against the
// pending sequence, and its zero, one or two results are written to a four-entry
// result queue that drives the output. While the output is not stalled, the input
// sustains one item per cycle and the output hands out one result per cycle, so a
// UTF-16 surrogate pair takes two output transfers, which the queue absorbs since
// a pair follows a four-byte sequence. Invalid bytes, overlong forms, surrogates and
// values above 10FFFF give one error result and the decoder returns to idle. The
// output_mode register (0 = UTF-16, 1 = UTF-32) is always ready and must be written
// only while the decoder is idle. Depends on u2u_pkg, u2u_dec and u2u_outq.
`default_nettype none

module utf8_stream_to_utf16_utf32 (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    input  wire logic               i_cfg_data,
    output logic                    o_cfg_ready,
    input  wire logic               i_in_valid,
    input  wire u2u_pkg::t_in_item  i_in_item,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    output u2u_pkg::t_out_item      o_out_item,
    input  wire logic               i_out_stall
);
    import u2u_pkg::*;

    logic  r_mode;
    logic  space;
    t_push push;

    // Output mode register; a transfer is taken in any cycle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_UTF16;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mode <= i_cfg_data;
        end
    end

    // Decode stage.
    u2u_dec u_dec (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mode     (r_mode),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_stall (o_in_stall),
        .i_space    (space),
        .o_push     (push)
    );

    // Result queue.
    u2u_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_space     (space),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire
